>>> src/scg_pkg.sv
// Package for the spreading code chip generator.
// Store geometry, accepted code lengths, LFSR tap masks and status codes.
// No dependencies.
package scg_pkg;

  localparam int unsigned STORE_DEPTH = 512;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [8:0] LEN_127 = 9'd127;
  localparam logic [8:0] LEN_255 = 9'd255;
  localparam logic [8:0] LEN_511 = 9'd511;

  localparam logic [8:0] TAPS_127 = 9'h060;
  localparam logic [8:0] TAPS_255 = 9'h0B8;
  localparam logic [8:0] TAPS_511 = 9'h110;

  localparam logic [8:0] LFSR_SEED = 9'd1;

  localparam logic signed [15:0] REF_POS = 16'sd32767;
  localparam logic signed [15:0] REF_NEG = -16'sd32767;

  typedef enum logic [1:0] {
    KIND_MSEQ   = 2'd0,
    KIND_GOLD   = 2'd1,
    KIND_KASAMI = 2'd2,
    KIND_STRICT = 2'd3
  } code_kind_e;

  typedef enum logic [1:0] {
    REG_KIND   = 2'd0,
    REG_LENGTH = 2'd1,
    REG_SHIFT  = 2'd2,
    REG_NONE   = 2'd3
  } reg_index_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_NO_GOLD = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

endpackage

>>> src/spreading_code_chip_generator_unit.sv
// Spreading code chip generator: m-sequence, Gold and small-set Kasami chips.
// One period of the base m-sequence sits in a 1-bit store filled by a Galois LFSR.
// Depends on scg_pkg.
//
// Usage:
//   Configuration words (kind, length, shift) come over the cfg channel;
//   cfg_ready_o is always high. Any write to a listed register restarts the
//   store fill: one LFSR step per cycle over code_length steps (127, 255 or 511).
//   The same fill runs after reset with the default length of 127.
//   While the fill runs, in_stall_o is high. With a bad length no fill runs.
// Chip requests enter on the input channel (in_valid_i, in_stall_o) and
// results leave on the output channel (out_valid_o, out_stall_i).
//   Throughput: one chip per cycle once the store is full and while the
//   receiver does not stall; the four pipeline stages are index/status, shift
//   reduction, decimation add + store read, and output register.
// When the receiver stalls, the whole pipeline holds and in_stall_o rises;
// nothing is lost or repeated. The decimated address x*q mod L is formed as
// x plus a rotation of x, since L = 2^d - 1 and q = 2^k + 1.
module spreading_code_chip_generator_unit
  import scg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [8:0]         chip_index_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               chip_bit_o,
  output logic signed [15:0] chip_ref_o,
  output logic               period_end_o,
  output logic [1:0]         status_o
);

  // configuration
  code_kind_e  kind_q;
  logic [8:0]  len_q;
  logic [8:0]  shift_q;
  logic [8:0]  shift_mod_q;

  // fill engine
  logic        ready_q;
  logic [8:0]  lfsr_q, lfsr_d;
  logic [8:0]  fill_cnt_q;
  logic        fill_active;

  logic        mem [STORE_DEPTH];

  logic        len_ok, is127, is255, is511;
  logic [8:0]  taps, deg_mask;
  logic        cfg_wr;

  // pipeline
  logic        en, acc;
  logic        v1_q, v2_q, v3_q, v4_q;
  logic [8:0]  idx1_q, idx2_q;
  logic [9:0]  sraw1_q;
  logic [1:0]  st1_q, st2_q, st3_q;
  logic        pe1_q, pe2_q, pe3_q;
  logic        xe1_q, xe2_q, xe3_q;
  logic [8:0]  s2_q, r2_q;
  logic        rd_a_q, rd_b_q;

  logic        bit4_q, pe4_q;
  logic [1:0]  st4_q;

  status_e     st_in;
  logic        xe_in;
  logic [9:0]  sraw_in;
  logic [9:0]  s_red;
  logic [8:0]  s_mod, r_rot;
  logic [9:0]  jsum, jred;
  logic [8:0]  j_addr;
  logic        chip;

  assign is127  = (len_q == LEN_127);
  assign is255  = (len_q == LEN_255);
  assign is511  = (len_q == LEN_511);
  assign len_ok = (is127 || is255 || is511) && ({1'b0, len_q} <= 10'(STORE_DEPTH));

  always_comb begin
    if (is127) begin
      taps     = TAPS_127;
      deg_mask = 9'h07F;
    end else if (is255) begin
      taps     = TAPS_255;
      deg_mask = 9'h0FF;
    end else begin
      taps     = TAPS_511;
      deg_mask = 9'h1FF;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && (cfg_index_i != REG_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_MSEQ;
      len_q       <= LEN_127;
      shift_q     <= '0;
      shift_mod_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_KIND:   kind_q  <= code_kind_e'(cfg_data_i[1:0]);
        REG_LENGTH: len_q   <= cfg_data_i;
        REG_SHIFT:  shift_q <= cfg_data_i;
        default: ;
      endcase
      shift_mod_q <= (cfg_index_i == REG_SHIFT) ? cfg_data_i : shift_q;
    end else if (shift_mod_q >= len_q) begin
      // settles by repeated subtraction, well before the fill ends
      shift_mod_q <= shift_mod_q - len_q;
    end
  end

  // ---------------------------------------------------------------- fill
  assign fill_active = !ready_q && len_ok;

  always_comb begin
    lfsr_d = lfsr_q >> 1;
    if (lfsr_q[0]) begin
      lfsr_d = lfsr_d ^ taps;
    end
    lfsr_d = lfsr_d & deg_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q    <= 1'b0;
      lfsr_q     <= LFSR_SEED;
      fill_cnt_q <= '0;
    end else if (cfg_wr) begin
      ready_q    <= 1'b0;
      lfsr_q     <= LFSR_SEED;
      fill_cnt_q <= '0;
    end else if (fill_active) begin
      lfsr_q     <= lfsr_d;
      fill_cnt_q <= fill_cnt_q + 9'd1;
      if (fill_cnt_q == len_q - 9'd1) begin
        ready_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_active && !cfg_wr) begin
      mem[fill_cnt_q[STORE_AW-1:0]] <= lfsr_q[0];
    end
  end

  // ------------------------------------------------------------ pipeline
  assign en         = !(v4_q && out_stall_i);
  assign in_stall_o = !en || fill_active;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    if (!len_ok) begin
      st_in = ST_BAD_LEN;
    end else if (kind_q == KIND_STRICT && is255) begin
      st_in = ST_NO_GOLD;
    end else if (chip_index_i >= len_q) begin
      st_in = ST_RANGE;
    end else begin
      st_in = ST_OK;
    end
    xe_in = ((kind_q == KIND_GOLD) && !is255) ||
            ((kind_q == KIND_KASAMI) && is255) ||
            (kind_q == KIND_STRICT);
    sraw_in = {1'b0, chip_index_i};
    if (kind_q == KIND_STRICT) begin
      sraw_in = {1'b0, chip_index_i} + {1'b0, shift_mod_q};
    end
  end

  // stage 2: (i + shift) mod L, then rotation giving x * 2^k mod L
  always_comb begin
    s_red = sraw1_q;
    if (sraw1_q >= {1'b0, len_q}) begin
      s_red = sraw1_q - {1'b0, len_q};
    end
    s_mod = s_red[8:0];
    if (is127) begin
      r_rot = {2'b00, s_mod[2:0], s_mod[6:3]};
    end else if (is255) begin
      r_rot = {1'b0, s_mod[3:0], s_mod[7:4]};
    end else begin
      r_rot = {s_mod[3:0], s_mod[8:4]};
    end
  end

  // stage 3: x + rot(x) mod L is the decimated address
  always_comb begin
    jsum = {1'b0, s2_q} + {1'b0, r2_q};
    jred = jsum;
    if (jsum >= {1'b0, len_q}) begin
      jred = jsum - {1'b0, len_q};
    end
    j_addr = jred[8:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q  <= chip_index_i;
      sraw1_q <= sraw_in;
      st1_q   <= st_in;
      pe1_q   <= (chip_index_i == len_q - 9'd1);
      xe1_q   <= xe_in;

      idx2_q  <= idx1_q;
      s2_q    <= s_mod;
      r2_q    <= r_rot;
      st2_q   <= st1_q;
      pe2_q   <= pe1_q;
      xe2_q   <= xe1_q;

      rd_a_q  <= mem[idx2_q[STORE_AW-1:0]];
      rd_b_q  <= mem[j_addr[STORE_AW-1:0]];
      st3_q   <= st2_q;
      pe3_q   <= pe2_q;
      xe3_q   <= xe2_q;

      bit4_q  <= (st3_q == ST_OK) && chip;
      pe4_q   <= (st3_q == ST_OK) && pe3_q;
      st4_q   <= st3_q;
    end
  end

  assign chip = rd_a_q ^ (xe3_q & rd_b_q);

  assign out_valid_o  = v4_q;
  assign chip_bit_o   = bit4_q;
  assign period_end_o = pe4_q;
  assign status_o     = st4_q;
  assign chip_ref_o   = (st4_q != ST_OK) ? 16'sd0 : (bit4_q ? REF_POS : REF_NEG);

endmodule
